// File: sv/ipp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_pkg - shared definitions of the intercept point predictor
// Default sizes, register map, register widths and the solution codes.
// ----------------------------------------------------------------------------
package ipp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Register widths and reset values.
	localparam int FALLBACK_W = 31;
	localparam int THRESH_W   = 16;
	localparam logic [FALLBACK_W-1:0] FALLBACK_RST = 31'd2185;
	localparam logic [THRESH_W-1:0]   THRESH_RST   = 16'd66;

	// Register index, taken from byte address bit 2.
	localparam logic REG_FALLBACK = 1'b0;
	localparam logic REG_THRESH   = 1'b1;

	// Solution codes.
	typedef enum logic [1:0] {
		KIND_BOTH     = 2'd0,
		KIND_MIXED    = 2'd1,
		KIND_LINEAR   = 2'd2,
		KIND_FALLBACK = 2'd3
	} kind_t;

endpackage

// File: sv/ipp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_div - pipelined time divider
// Signed quotient num/den truncated toward zero and saturated to a CW-bit
// time, one quotient bit per stage. Side data travels with each item.
// ----------------------------------------------------------------------------
module ipp_div #(
	parameter int CW  = 32,
	parameter int NW  = 100,
	parameter int DNW = 67,
	parameter int SW  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [NW-1:0]  num,
	input  logic signed [DNW-1:0] den,
	input  logic [SW-1:0]         side_in,
	output logic                  out_valid,
	output logic signed [CW-1:0]  quot,
	output logic [SW-1:0]         side_out
);

	localparam int XW = NW + CW;
	localparam int NS = CW - 1;
	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] QTOP = {1'b1, {(CW-1){1'b0}}};

	logic [NW-1:0]  n_abs;
	logic [DNW-1:0] d_abs;

	logic           dv_s   [0:NS];
	logic [NW-1:0]  dn_s   [0:NS];
	logic [DNW-1:0] dd_s   [0:NS];
	logic [CW-1:0]  dq_s   [0:NS];
	logic           dneg_s [0:NS];
	logic           dsat_s [0:NS];
	logic [SW-1:0]  dside_s[0:NS];

	logic [CW-1:0]  q_full;

	assign n_abs = num[NW-1] ? NW'(-num) : NW'(num);
	assign d_abs = den[DNW-1] ? DNW'(-den) : DNW'(den);

	// Entry stage: magnitudes, sign of the result and the saturation test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else begin
			dv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dn_s[0]    <= n_abs;
		dd_s[0]    <= d_abs;
		dq_s[0]    <= '0;
		dneg_s[0]  <= num[NW-1] ^ den[DNW-1];
		dsat_s[0]  <= XW'(n_abs) >= (XW'(d_abs) << (CW - 1));
		dside_s[0] <= side_in;
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar i = 0; i < NS; i++) begin : g_step
		localparam int K = CW - 2 - i;
		logic [XW-1:0] shifted;
		logic          take;

		assign shifted = XW'(dd_s[i]) << K;
		assign take    = !dsat_s[i] && (XW'(dn_s[i]) >= shifted);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[i+1] <= 1'b0;
			end else begin
				dv_s[i+1] <= dv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			dn_s[i+1]    <= take ? NW'(XW'(dn_s[i]) - shifted) : dn_s[i];
			dq_s[i+1]    <= dq_s[i] | (take ? (CW'(1) << K) : '0);
			dd_s[i+1]    <= dd_s[i];
			dneg_s[i+1]  <= dneg_s[i];
			dsat_s[i+1]  <= dsat_s[i];
			dside_s[i+1] <= dside_s[i];
		end
	end

	assign q_full = dsat_s[NS] ? QTOP : dq_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dv_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (dneg_s[NS]) begin
			quot <= $signed(-q_full);
		end else begin
			quot <= q_full[CW-1] ? $signed(CMAX) : $signed(q_full);
		end
		side_out <= dside_s[NS];
	end

endmodule

// File: sv/intercept_point_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intercept_point_predictor - projectile lead solver
// Solves a*t^2 + b*t + c = 0 for the intercept time of a moving target and
// returns the target position at that time, with a solution code.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer
//  -------   ---------------------------------------   ---------------------------
//  request   start, busy, target_*, shooter_*,         start high while busy low
//            projectile_speed
//  result    done, aim_x, aim_y, hold_fire,            done high for one cycle
//            solution_kind
//  config    psel, penable, pwrite, paddr, pwdata,     psel, penable, pwrite,
//            prdata, pready                            pready all high
//
//  One request transfer is taken in every clock cycle; busy is always low.
//  The depth of the pipeline is set by the square-root pipeline, one root
//  bit per stage over the 4*COORD_WIDTH+6 bit discriminant, and the two
//  dividers, one quotient bit per stage.
//  Reset clears every valid bit and loads the registers with their reset
//  values; no clearing pass is needed. The receiver cannot stall, so results
//  leave the pipeline at the rate requests entered it.
//
// ----------------------------------------------------------------------------
module intercept_point_predictor #(
	parameter int COORD_WIDTH = ipp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = ipp_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] target_x,
	input  logic signed [COORD_WIDTH-1:0] target_y,
	input  logic signed [COORD_WIDTH-1:0] target_vx,
	input  logic signed [COORD_WIDTH-1:0] target_vy,
	input  logic signed [COORD_WIDTH-1:0] shooter_x,
	input  logic signed [COORD_WIDTH-1:0] shooter_y,
	input  logic [COORD_WIDTH-2:0]        projectile_speed,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// result channel
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] aim_x,
	output logic signed [COORD_WIDTH-1:0] aim_y,
	output logic                          hold_fire,
	output logic [1:0]                    solution_kind
);

	localparam int CW  = COORD_WIDTH;
	localparam int FB  = FRAC_BITS;
	// Exact widths of the quadratic's coefficients.
	localparam int AW  = 2*CW + 1;       // a, signed
	localparam int AMW = 2*CW;           // |a|
	localparam int BW  = 2*CW + 3;       // b, signed
	localparam int BMW = 2*CW + 2;       // |b|
	localparam int CCW = 2*CW + 2;       // c, never negative
	localparam int HB  = CW + 1;         // half of |b| for the square
	localparam int HA  = CW;             // half of |a|
	localparam int HC  = CW + 1;         // half of c
	localparam int DW  = 4*CW + 6;       // discriminant, signed, even
	localparam int NSQ = DW / 2;         // root bits, one per stage
	localparam int RW  = 2*CW + 4;       // root width
	localparam int NW  = 2*CW + 5 + FB;  // divider numerator
	localparam int DNW = 2*CW + 3;       // divider denominator
	localparam int TW  = BMW + ipp_pkg::THRESH_W + FB;
	localparam int PVW = 4*CW;
	localparam int FLW = CW + 3;
	// Cycles from the accepting edge to the edge that takes the result.
	localparam int LATENCY = NSQ + CW + 11;

	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [2*CW:0] RMAX = (2*CW+1)'(CMAX);
	localparam logic signed [2*CW:0] RMIN = -RMAX - 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ipp_pkg::FALLBACK_W-1:0] fallback_time_q;
	logic [ipp_pkg::THRESH_W-1:0]   zero_threshold_q;
	logic                           cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_time_q  <= ipp_pkg::FALLBACK_RST;
			zero_threshold_q <= ipp_pkg::THRESH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ipp_pkg::REG_FALLBACK: fallback_time_q  <= pwdata[ipp_pkg::FALLBACK_W-1:0];
				ipp_pkg::REG_THRESH:   zero_threshold_q <= pwdata[ipp_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ipp_pkg::REG_FALLBACK: prdata = 32'(fallback_time_q);
			ipp_pkg::REG_THRESH:   prdata = 32'(zero_threshold_q);
			default:               prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: offsets from the shooter to the target.
	// ------------------------------------------------------------------
	logic                 v_s1;
	logic signed [CW:0]   dx_s1, dy_s1;
	logic signed [CW-1:0] vx_s1, vy_s1;
	logic [CW-2:0]        ls_s1;
	logic [PVW-1:0]       pv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= (CW+1)'(target_x) - (CW+1)'(shooter_x);
		dy_s1 <= (CW+1)'(target_y) - (CW+1)'(shooter_y);
		vx_s1 <= target_vx;
		vy_s1 <= target_vy;
		ls_s1 <= projectile_speed;
		pv_s1 <= {target_x, target_y, target_vx, target_vy};
	end

	// ------------------------------------------------------------------
	// Stage 2: the seven coordinate products.
	// ------------------------------------------------------------------
	logic                   v_s2;
	logic signed [2*CW-1:0] vxx_s2, vyy_s2;
	logic [2*CW-3:0]        lss_s2;
	logic signed [2*CW:0]   dxvx_s2, dyvy_s2;
	logic signed [2*CW+1:0] dxx_s2, dyy_s2;
	logic [PVW-1:0]         pv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		vxx_s2  <= vx_s1 * vx_s1;
		vyy_s2  <= vy_s1 * vy_s1;
		lss_s2  <= ls_s1 * ls_s1;
		dxvx_s2 <= dx_s1 * vx_s1;
		dyvy_s2 <= dy_s1 * vy_s1;
		dxx_s2  <= dx_s1 * dx_s1;
		dyy_s2  <= dy_s1 * dy_s1;
		pv_s2   <= pv_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: coefficients a, b and c.
	// ------------------------------------------------------------------
	logic                 v_s3;
	logic signed [AW-1:0] a_s3;
	logic signed [BW-1:0] b_s3;
	logic [CCW-1:0]       c_s3;
	logic [PVW-1:0]       pv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s3  <= AW'(vxx_s2) + AW'(vyy_s2) - $signed(AW'(lss_s2));
		b_s3  <= (BW'(dxvx_s2) + BW'(dyvy_s2)) <<< 1;
		c_s3  <= CCW'(dxx_s2) + CCW'(dyy_s2);
		pv_s3 <= pv_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: zero tests, the degenerate time and the partial products of
	// b*b and |a|*c.
	// ------------------------------------------------------------------
	logic [AMW-1:0]     a_abs;
	logic [BMW-1:0]     b_abs;
	logic [TW-1:0]      thr;
	logic [CCW-FB-1:0]  c_scaled;

	assign a_abs    = a_s3[AW-1] ? AMW'(-a_s3) : AMW'(a_s3);
	assign b_abs    = b_s3[BW-1] ? BMW'(-b_s3) : BMW'(b_s3);
	assign thr      = TW'(zero_threshold_q) << FB;
	assign c_scaled = c_s3[CCW-1:FB];

	logic                 v_s4;
	logic signed [AW-1:0] a_s4;
	logic signed [BW-1:0] b_s4;
	logic [CCW-1:0]       c_s4;
	logic [PVW-1:0]       pv_s4;
	logic                 lin_s4, linb_s4;
	logic [CW-1:0]        tc_s4;
	logic [2*HB-1:0]      bb_ll_s4, bb_lh_s4, bb_hh_s4;
	logic [HA+HC-1:0]     ac_ll_s4, ac_lh_s4, ac_hl_s4, ac_hh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		a_s4     <= a_s3;
		b_s4     <= b_s3;
		c_s4     <= c_s3;
		pv_s4    <= pv_s3;
		lin_s4   <= TW'(a_abs) <= thr;
		linb_s4  <= TW'(b_abs) <= thr;
		tc_s4    <= (CCW'(c_scaled) >= CCW'(CMAX)) ? CMAX : c_scaled[CW-1:0];
		bb_ll_s4 <= b_abs[HB-1:0] * b_abs[HB-1:0];
		bb_lh_s4 <= b_abs[HB-1:0] * b_abs[2*HB-1:HB];
		bb_hh_s4 <= b_abs[2*HB-1:HB] * b_abs[2*HB-1:HB];
		ac_ll_s4 <= a_abs[HA-1:0] * c_s3[HC-1:0];
		ac_lh_s4 <= a_abs[HA-1:0] * c_s3[2*HC-1:HC];
		ac_hl_s4 <= a_abs[2*HA-1:HA] * c_s3[HC-1:0];
		ac_hh_s4 <= a_abs[2*HA-1:HA] * c_s3[2*HC-1:HC];
	end

	// ------------------------------------------------------------------
	// Stage 5: b*b and |a|*c assembled from their partial products.
	// ------------------------------------------------------------------
	logic                 v_s5;
	logic [DW-1:0]        bb_s5, ac_s5;
	logic signed [AW-1:0] a_s5;
	logic signed [BW-1:0] b_s5;
	logic [CCW-1:0]       c_s5;
	logic [PVW-1:0]       pv_s5;
	logic                 lin_s5, linb_s5;
	logic [CW-1:0]        tc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		bb_s5   <= (DW'(bb_hh_s4) << (2*HB)) + (DW'(bb_lh_s4) << (HB + 1)) + DW'(bb_ll_s4);
		ac_s5   <= (DW'(ac_hh_s4) << (HA + HC)) + (DW'(ac_lh_s4) << HC)
			+ (DW'(ac_hl_s4) << HA) + DW'(ac_ll_s4);
		a_s5    <= a_s4;
		b_s5    <= b_s4;
		c_s5    <= c_s4;
		pv_s5   <= pv_s4;
		lin_s5  <= lin_s4;
		linb_s5 <= linb_s4;
		tc_s5   <= tc_s4;
	end

	// ------------------------------------------------------------------
	// Stage 6: discriminant b*b - 4*a*c; it seeds the root pipeline.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] disc;

	assign disc = a_s5[AW-1] ? $signed(bb_s5 + (ac_s5 << 2)) : $signed(bb_s5 - (ac_s5 << 2));

	logic                 sq_v_s   [0:NSQ];
	logic [DW-1:0]        sq_rem_s [0:NSQ];
	logic [DW-1:0]        sq_res_s [0:NSQ];
	logic signed [AW-1:0] sq_a_s   [0:NSQ];
	logic signed [BW-1:0] sq_b_s   [0:NSQ];
	logic [CCW-1:0]       sq_c_s   [0:NSQ];
	logic [PVW-1:0]       sq_pv_s  [0:NSQ];
	logic [FLW-1:0]       sq_fl_s  [0:NSQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else begin
			sq_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0] <= disc[DW-1] ? '0 : DW'(disc);
		sq_res_s[0] <= '0;
		sq_a_s[0]   <= a_s5;
		sq_b_s[0]   <= b_s5;
		sq_c_s[0]   <= c_s5;
		sq_pv_s[0]  <= pv_s5;
		// Flags: linear, b near zero, negative discriminant, then the time c.
		sq_fl_s[0]  <= {lin_s5, linb_s5, disc[DW-1], tc_s5};
	end

	// Integer square root, one result bit per stage.
	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		localparam int SH = DW - 2 - 2*j;
		logic [DW-1:0] bitv;
		logic [DW-1:0] trial;

		assign bitv  = DW'(1) << SH;
		assign trial = sq_res_s[j] + bitv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j+1] <= 1'b0;
			end else begin
				sq_v_s[j+1] <= sq_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (sq_rem_s[j] >= trial) begin
				sq_rem_s[j+1] <= sq_rem_s[j] - trial;
				sq_res_s[j+1] <= (sq_res_s[j] >> 1) + bitv;
			end else begin
				sq_rem_s[j+1] <= sq_rem_s[j];
				sq_res_s[j+1] <= sq_res_s[j] >> 1;
			end
			sq_a_s[j+1]  <= sq_a_s[j];
			sq_b_s[j+1]  <= sq_b_s[j];
			sq_c_s[j+1]  <= sq_c_s[j];
			sq_pv_s[j+1] <= sq_pv_s[j];
			sq_fl_s[j+1] <= sq_fl_s[j];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: numerators and denominators of both roots. The first divider
	// also serves the linear case, -c/b.
	// ------------------------------------------------------------------
	logic [RW-1:0]         root;
	logic signed [NW-1:0]  n_root1, n_root2, n_lin;
	logic                  lin_sq;

	assign root    = sq_res_s[NSQ][RW-1:0];
	assign lin_sq  = sq_fl_s[NSQ][FLW-1];
	assign n_root1 = (NW'(root) - NW'(sq_b_s[NSQ])) <<< FB;
	assign n_root2 = (-(NW'(sq_b_s[NSQ]) + NW'(root))) <<< FB;
	assign n_lin   = -(NW'(sq_c_s[NSQ]) <<< FB);

	logic                  v_s7;
	logic signed [NW-1:0]  num1_s7, num2_s7;
	logic signed [DNW-1:0] den1_s7, den2_s7;
	logic [PVW-1:0]        pv_s7;
	logic [FLW-1:0]        fl_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= sq_v_s[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		num1_s7 <= lin_sq ? n_lin : n_root1;
		den1_s7 <= lin_sq ? DNW'(sq_b_s[NSQ]) : (DNW'(sq_a_s[NSQ]) <<< 1);
		num2_s7 <= n_root2;
		den2_s7 <= DNW'(sq_a_s[NSQ]) <<< 1;
		pv_s7   <= sq_pv_s[NSQ];
		fl_s7   <= sq_fl_s[NSQ];
	end

	logic                 q1_v, q2_v;
	logic signed [CW-1:0] q1, q2;
	logic [PVW-1:0]       pv_dv;
	logic [FLW-1:0]       fl_dv;

	ipp_div #(.CW(CW), .NW(NW), .DNW(DNW), .SW(PVW)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.num      (num1_s7),
		.den      (den1_s7),
		.side_in  (pv_s7),
		.out_valid(q1_v),
		.quot     (q1),
		.side_out (pv_dv)
	);

	ipp_div #(.CW(CW), .NW(NW), .DNW(DNW), .SW(FLW)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.num      (num2_s7),
		.den      (den2_s7),
		.side_in  (fl_s7),
		.out_valid(q2_v),
		.quot     (q2),
		.side_out (fl_dv)
	);

	// ------------------------------------------------------------------
	// Stage 8: pick the intercept time and the solution code.
	// ------------------------------------------------------------------
	localparam int FXW = ipp_pkg::FALLBACK_W + CW;
	localparam int ZXW = ipp_pkg::THRESH_W + CW;

	logic                 f_lin, f_linb, f_dneg;
	logic signed [CW-1:0] t_lin, fb_sat;
	logic [CW-1:0]        t_lin_abs;
	logic signed [CW-1:0] t_pick;
	ipp_pkg::kind_t       kind_pick;

	assign f_lin     = fl_dv[FLW-1];
	assign f_linb    = fl_dv[FLW-2];
	assign f_dneg    = fl_dv[FLW-3];
	assign t_lin     = f_linb ? $signed(fl_dv[CW-1:0]) : q1;
	assign t_lin_abs = t_lin[CW-1] ? CW'(-t_lin) : CW'(t_lin);
	assign fb_sat    = (FXW'(fallback_time_q) > FXW'(CMAX)) ? $signed(CMAX)
		: $signed(CW'(fallback_time_q));

	always_comb begin
		t_pick    = t_lin;
		kind_pick = ipp_pkg::KIND_FALLBACK;
		if (f_lin) begin
			// The linear time counts only when it is clear of zero.
			if (ZXW'(t_lin_abs) > ZXW'(zero_threshold_q)) begin
				kind_pick = ipp_pkg::KIND_LINEAR;
			end
		end else if (!f_dneg) begin
			if (!q1[CW-1] && !q2[CW-1]) begin
				kind_pick = ipp_pkg::KIND_BOTH;
				t_pick    = (q1 < q2) ? q1 : q2;
			end else if (q1[CW-1] != q2[CW-1]) begin
				kind_pick = ipp_pkg::KIND_MIXED;
				t_pick    = (q1 > q2) ? q1 : q2;
			end
		end
		if (kind_pick == ipp_pkg::KIND_FALLBACK) begin
			t_pick = fb_sat;
		end
	end

	logic                 v_s8;
	logic signed [CW-1:0] t_s8;
	ipp_pkg::kind_t       kind_s8;
	logic [PVW-1:0]       pv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= q1_v && q2_v;
		end
	end

	always_ff @(posedge clk) begin
		t_s8    <= t_pick;
		kind_s8 <= kind_pick;
		pv_s8   <= pv_dv;
	end

	// ------------------------------------------------------------------
	// Stage 9: travel of the target over the chosen time.
	// ------------------------------------------------------------------
	logic                   v_s9;
	logic signed [2*CW-1:0] mvx_s9, mvy_s9;
	logic signed [CW-1:0]   tx_s9, ty_s9;
	ipp_pkg::kind_t         kind_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		mvx_s9  <= $signed(pv_s8[2*CW-1:CW]) * t_s8;
		mvy_s9  <= $signed(pv_s8[CW-1:0]) * t_s8;
		tx_s9   <= $signed(pv_s8[4*CW-1:3*CW]);
		ty_s9   <= $signed(pv_s8[3*CW-1:2*CW]);
		kind_s9 <= kind_s8;
	end

	// ------------------------------------------------------------------
	// Stage 10: aim point, saturated to the coordinate range.
	// ------------------------------------------------------------------
	logic signed [2*CW:0] rx, ry;

	assign rx = (2*CW+1)'(mvx_s9 >>> FB) + (2*CW+1)'(tx_s9);
	assign ry = (2*CW+1)'(mvy_s9 >>> FB) + (2*CW+1)'(ty_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (rx >= RMAX) begin
			aim_x <= $signed(CMAX);
		end else if (rx <= RMIN) begin
			aim_x <= $signed(~CMAX);
		end else begin
			aim_x <= CW'(rx);
		end
		if (ry >= RMAX) begin
			aim_y <= $signed(CMAX);
		end else if (ry <= RMIN) begin
			aim_y <= $signed(~CMAX);
		end else begin
			aim_y <= CW'(ry);
		end
		hold_fire     <= kind_s9 == ipp_pkg::KIND_FALLBACK;
		solution_kind <= kind_s9;
	end

endmodule

// File: sv/ipp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_checker - port checks of the intercept point predictor
// Watches the top level's ports and reports rule breaks.
// ----------------------------------------------------------------------------
module ipp_checker #(
	parameter int LATENCY = 110
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       hold_fire,
	input logic [1:0] solution_kind
);

	// Every result stems from a request taken at the pipeline depth given by LATENCY.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a request at the pipeline depth");

	// The fallback code and hold_fire always come together.
	a_hold_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && hold_fire |-> solution_kind == ipp_pkg::KIND_FALLBACK)
		else $error("hold_fire without the fallback code");

	a_kind_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && solution_kind == ipp_pkg::KIND_FALLBACK |-> hold_fire)
		else $error("fallback code without hold_fire");

	// The pipeline takes a request in every cycle.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("request refused");

endmodule

bind intercept_point_predictor ipp_checker #(.LATENCY(LATENCY)) u_ipp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hold_fire    (hold_fire),
	.solution_kind(solution_kind)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of the intercept point predictor
// Streams target/shooter transfers into the solver, predicts the results with
// a wide exact-arithmetic lead solver of its own (or takes a typed-in value for
// directed rows), and compares each result transfer with the oldest prediction.
// Register settings change between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CW   = ipp_pkg::COORD_WIDTH_DEF;
	localparam int FB   = ipp_pkg::FRAC_BITS_DEF;
	localparam int WW   = 192;
	localparam int LAT  = 3 * CW + 14;
	localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 390;

	typedef logic signed [WW-1:0] wide_t;

	typedef struct {
		logic signed [CW-1:0] tx, ty, vx, vy, sx, sy;
		logic [CW-2:0]        ls;
	} query_t;

	typedef struct {
		logic signed [CW-1:0] ax, ay;
		logic                 hold;
		ipp_pkg::kind_t       kind;
	} aim_t;

	typedef struct {
		query_t q;
		bit     has_aim;
		aim_t   a;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] target_x = '0, target_y = '0, target_vx = '0, target_vy = '0;
	logic signed [CW-1:0] shooter_x = '0, shooter_y = '0;
	logic [CW-2:0] projectile_speed = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic done;
	logic signed [CW-1:0] aim_x, aim_y;
	logic hold_fire;
	logic [1:0] solution_kind;

	// Fixed expectation for directed rows, driven alongside the request.
	logic cur_fixed = 1'b0;
	aim_t cur_aim;

	aim_t aim_queue[$];
	logic [ipp_pkg::FALLBACK_W-1:0] fallback_reg = ipp_pkg::FALLBACK_RST;
	logic [ipp_pkg::THRESH_W-1:0]   thresh_reg   = ipp_pkg::THRESH_RST;
	int errors = 0;
	int cycles = 0;
	row_t rows[$];

	intercept_point_predictor u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.target_x(target_x), .target_y(target_y),
		.target_vx(target_vx), .target_vy(target_vy),
		.shooter_x(shooter_x), .shooter_y(shooter_y),
		.projectile_speed(projectile_speed),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.done(done), .aim_x(aim_x), .aim_y(aim_y),
		.hold_fire(hold_fire), .solution_kind(solution_kind)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Append one expectation at the tail of the scoreboard.
	function automatic void queue_aim(aim_t a);
		aim_queue.insert(aim_queue.size(), a);
	endfunction

	// Append one directed row at the tail of the stimulus table.
	function automatic void add_row(row_t r);
		rows.insert(rows.size(), r);
	endfunction

	// Floor of the exact square root, one result bit per pass.
	function automatic wide_t isqrt(wide_t n);
		logic [WW-1:0] rem, res, bt;
		begin
			rem = n;
			res = '0;
			bt = {{(WW-1){1'b0}}, 1'b1} << (WW - 2);
			while (bt != 0) begin
				if (rem >= res + bt) begin
					rem = rem - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			return res;
		end
	endfunction

	// Quotient truncated toward zero and clamped to the signed time range.
	function automatic longint lead_div(wide_t num, wide_t den);
		wide_t n, d, qw;
		logic neg;
		longint q;
		begin
			neg = num[WW-1] != den[WW-1];
			n = num[WW-1] ? -num : num;
			d = den[WW-1] ? -den : den;
			if (n >= (d <<< (CW - 1))) begin
				q = 64'sd1 <<< (CW - 1);
			end else begin
				qw = n / d;
				q = qw[63:0];
			end
			if (neg) return -q;
			return q > CMAX ? CMAX : q;
		end
	endfunction

	// Position advanced by velocity*t, saturated to the coordinate range.
	function automatic logic signed [CW-1:0] advance(logic signed [CW-1:0] p,
			logic signed [CW-1:0] v, longint t);
		wide_t r, wv, wt, wp;
		begin
			wv = wide_t'(v);
			wt = wide_t'(t);
			wp = wide_t'(p);
			r = ((wv * wt) >>> FB) + wp;
			if (r >= wide_t'(CMAX)) return CMAX[CW-1:0];
			if (r <= wide_t'(CMIN)) return CMIN[CW-1:0];
			return r[CW-1:0];
		end
	endfunction

	// Lead solution for one query under the current register settings.
	function automatic aim_t solve_lead(query_t q);
		wide_t dx, dy, vx, vy, ls, a, b, c, thr, disc, s, den, cs, aa, ab;
		longint t, t1, t2, tabs;
		ipp_pkg::kind_t kind;
		aim_t r;
		begin
			dx = wide_t'(q.tx) - wide_t'(q.sx);
			dy = wide_t'(q.ty) - wide_t'(q.sy);
			vx = wide_t'(q.vx);
			vy = wide_t'(q.vy);
			ls = wide_t'($signed({1'b0, q.ls}));
			a = vx * vx + vy * vy - ls * ls;
			b = (dx * vx + dy * vy) <<< 1;
			c = dx * dx + dy * dy;
			thr = wide_t'($signed({1'b0, thresh_reg})) <<< FB;
			aa = a[WW-1] ? -a : a;
			ab = b[WW-1] ? -b : b;
			t = 0;
			if (aa <= thr) begin
				// Near-zero a: linear solve, or plain c when b is near zero too.
				if (ab <= thr) begin
					cs = c >>> FB;
					t = cs >= wide_t'(CMAX) ? CMAX : longint'(cs[63:0]);
				end else begin
					t = lead_div(-(c <<< FB), b);
				end
				tabs = t < 0 ? -t : t;
				kind = tabs <= longint'(thresh_reg) ? ipp_pkg::KIND_FALLBACK
					: ipp_pkg::KIND_LINEAR;
			end else begin
				disc = b * b - ((a * c) <<< 2);
				if (disc[WW-1]) begin
					kind = ipp_pkg::KIND_FALLBACK;
				end else begin
					s = isqrt(disc);
					den = a <<< 1;
					t1 = lead_div((s - b) <<< FB, den);
					t2 = lead_div((-(b + s)) <<< FB, den);
					if (t1 < 0 && t2 < 0) begin
						kind = ipp_pkg::KIND_FALLBACK;
					end else if (t1 >= 0 && t2 >= 0) begin
						kind = ipp_pkg::KIND_BOTH;
						t = t1 < t2 ? t1 : t2;
					end else begin
						kind = ipp_pkg::KIND_MIXED;
						t = t1 > t2 ? t1 : t2;
					end
				end
			end
			if (kind == ipp_pkg::KIND_FALLBACK) t = longint'(fallback_reg);
			r.ax = advance(q.tx, q.vx, t);
			r.ay = advance(q.ty, q.vy, t);
			r.hold = kind == ipp_pkg::KIND_FALLBACK;
			r.kind = kind;
			return r;
		end
	endfunction

	// Request transfers: record the expected result at the accepting edge.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (cur_fixed) queue_aim(cur_aim);
			else queue_aim(solve_lead('{target_x, target_y, target_vx,
				target_vy, shooter_x, shooter_y, projectile_speed}));
		end
	end

	// Result transfers: compare field by field with the oldest expectation.
	always @(posedge clk) begin
		aim_t e;
		if (arst_n && done) begin
			if (aim_queue.size() == 0) begin
				$error("result transfer with no expectation pending");
				errors++;
			end else begin
				e = aim_queue.pop_front();
				if (aim_x !== e.ax) begin
					$error("aim_x expected %0d actual %0d", e.ax, aim_x);
					errors++;
				end
				if (aim_y !== e.ay) begin
					$error("aim_y expected %0d actual %0d", e.ay, aim_y);
					errors++;
				end
				if (hold_fire !== e.hold) begin
					$error("hold_fire expected %0d actual %0d", e.hold, hold_fire);
					errors++;
				end
				if (solution_kind !== e.kind) begin
					$error("solution_kind expected %0d actual %0d", e.kind, solution_kind);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Register write with a setup and an access phase; the register takes the value at the access edge.
	// The port then idles before anything else is driven on it.
	task automatic reg_write(logic idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == ipp_pkg::REG_FALLBACK) fallback_reg = val[ipp_pkg::FALLBACK_W-1:0];
		else thresh_reg = val[ipp_pkg::THRESH_W-1:0];
		@(posedge clk);
	endtask

	// Offer one request and hold it until the transfer completes.
	task automatic offer(query_t q, bit fixed, aim_t a);
		start <= 1'b1;
		target_x <= q.tx;
		target_y <= q.ty;
		target_vx <= q.vx;
		target_vy <= q.vy;
		shooter_x <= q.sx;
		shooter_y <= q.sy;
		projectile_speed <= q.ls;
		cur_fixed <= fixed;
		cur_aim <= a;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait for the pipeline to drain, then longer than its full depth for safety.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (aim_queue.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	// Random coordinate: full range now and then, otherwise a modest spread
	// that keeps the quadratic well conditioned and reaches every solution kind.
	function automatic logic signed [CW-1:0] rand_coord(int spread);
		case ($urandom_range(0, 9))
			0: return CW'($urandom);
			1: return CW'($signed($urandom_range(0, 65535)) - 32768);
			default: return CW'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int vs;
		begin
			vs = 1 << $urandom_range(14, 22);
			q.tx = rand_coord(1 << 24);
			q.ty = rand_coord(1 << 24);
			q.sx = rand_coord(1 << 24);
			q.sy = rand_coord(1 << 24);
			q.vx = rand_coord(vs);
			q.vy = rand_coord(vs);
			case ($urandom_range(0, 5))
				0: q.ls = (CW-1)'($urandom);
				1: q.ls = '0;
				default: q.ls = (CW-1)'($urandom_range(0, 2 * vs));
			endcase
			return q;
		end
	endfunction

	function automatic row_t mk(query_t q, bit fixed, logic signed [CW-1:0] ax,
			logic signed [CW-1:0] ay, logic hold, ipp_pkg::kind_t kind);
		row_t r;
		begin
			r.q = q;
			r.has_aim = fixed;
			r.a = '{ax, ay, hold, kind};
			return r;
		end
	endfunction

	initial begin
		aim_t none;
		query_t q;
		logic [31:0] fb_set[N_PHASES];
		logic [31:0] th_set[N_PHASES];
		none = '{'0, '0, 1'b0, ipp_pkg::KIND_BOTH};

		// Directed rows. Expected values are typed in only where obvious.
		// Everything at zero: zero time, so the fallback applies and the aim stays put.
		add_row(mk('{0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 1'b1, ipp_pkg::KIND_FALLBACK));
		// Stationary target, no projectile speed, far away: linear with a huge c,
		// the aim is the target itself.
		add_row(mk('{32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh80000000,
			32'sh7FFFFFFF, 0}, 1, 32'sh7FFFFFFF, 32'sh80000000, 1'b0,
			ipp_pkg::KIND_LINEAR));
		// Stationary target, moving shooter bullet: roots of mixed sign.
		add_row(mk('{32'sd655360, 32'sd0, 0, 0, 0, 0, 31'd65536}, 1,
			32'sd655360, 32'sd0, 1'b0, ipp_pkg::KIND_MIXED));
		add_row(mk('{32'sh80000000, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF,
			32'sh80000000, 31'h7FFFFFFF}, 1, 32'sh80000000, 32'sh7FFFFFFF, 1'b0,
			ipp_pkg::KIND_MIXED));
		// Fast target approaching: both roots non-negative.
		add_row(mk('{32'sd6553600, 0, -32'sd196608, 0, 0, 0, 31'd65536}, 0,
			0, 0, 0, ipp_pkg::KIND_BOTH));
		// Fast target receding: both roots negative, fallback.
		add_row(mk('{32'sd6553600, 0, 32'sd196608, 0, 0, 0, 31'd65536}, 0,
			0, 0, 0, ipp_pkg::KIND_BOTH));
		// Target faster than bullet crossing off axis: negative discriminant.
		add_row(mk('{32'sd6553600, 32'sd6553600, 0, 32'sd655360, 0, 0,
			31'd65536}, 0, 0, 0, 0, ipp_pkg::KIND_BOTH));
		// Equal speeds: a is zero, linear solve of -c/b.
		add_row(mk('{32'sd6553600, 0, -32'sd65536, 0, 0, 0, 31'd65536}, 0,
			0, 0, 0, ipp_pkg::KIND_BOTH));
		add_row(mk('{32'sd6553600, 0, 32'sd65536, 0, 0, 0, 31'd65536}, 0,
			0, 0, 0, ipp_pkg::KIND_BOTH));
		// Extreme velocities, saturating the aim.
		add_row(mk('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			0, 0, 0}, 0, 0, 0, 0, ipp_pkg::KIND_BOTH));
		add_row(mk('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF}, 0, 0, 0, 0,
			ipp_pkg::KIND_BOTH));
		// Tiny separation: linear time near zero falls back. Then a and b both near zero.
		add_row(mk('{32'sd1, 32'sd1, 0, 0, 0, 0, 0}, 0, 0, 0, 0, ipp_pkg::KIND_BOTH));
		add_row(mk('{32'sd65536, 0, -32'sd3, 0, 0, 0, 31'd3}, 0, 0, 0, 0,
			ipp_pkg::KIND_BOTH));
		// All ones and alternating patterns.
		add_row(mk('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			31'h7FFFFFFF}, 0, 0, 0, 0, ipp_pkg::KIND_BOTH));
		add_row(mk('{32'sh55555555, 32'shAAAAAAAA, 32'sh00005555, 32'shFFFFAAAA,
			32'shAAAAAAAA, 32'sh55555555, 31'h2AAAAAAA}, 0, 0, 0, 0,
			ipp_pkg::KIND_BOTH));

		// Register settings per phase: reset values, extremes, then random ones.
		fb_set[0] = 32'(ipp_pkg::FALLBACK_RST);   th_set[0] = 32'(ipp_pkg::THRESH_RST);
		fb_set[1] = 32'd0;          th_set[1] = 32'd0;
		fb_set[2] = 32'h7FFFFFFF;   th_set[2] = 32'hFFFF;
		fb_set[3] = $urandom;       th_set[3] = $urandom_range(0, 4000);
		fb_set[4] = $urandom_range(0, 1 << 20); th_set[4] = $urandom_range(0, 65535);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings, back to back.
		foreach (rows[i]) offer(rows[i].q, rows[i].has_aim, rows[i].a);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			reg_write(ipp_pkg::REG_FALLBACK, fb_set[ph]);
			reg_write(ipp_pkg::REG_THRESH, th_set[ph]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				q = rand_query();
				offer(q, 1'b0, none);
				// Random idle bursts, none in the final phase.
				if (ph < N_PHASES - 1 && $urandom_range(0, 9) == 0)
					pause($urandom_range(1, 17));
			end
			// The sender holds off until every pending result has come back.
			drain();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/ipp_pkg.sv
sv/ipp_div.sv
sv/intercept_point_predictor.sv
sv/ipp_checker.sv
tb/tb_top.sv
